FILE: rtl/gps_ca_code_sample_generator_defines.svh
// Assertion macros shared by the code generator RTL.
`ifndef GPS_CA_CODE_SAMPLE_GENERATOR_DEFINES_SVH
`define GPS_CA_CODE_SAMPLE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GCSG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gcsg check failed");

// Next-cycle implication, checked out of reset.
`define GCSG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gcsg check failed");

`endif

FILE: rtl/gcsg_pkg.sv
// Types, constants and the G2 tap table of the C/A code sample generator.
package gcsg_pkg;

    localparam int SCW        = 26;               // sample count / phase width
    localparam int CHIP_W     = 10;
    localparam int LFSR_W     = 10;
    localparam int PRN_W      = 6;
    localparam int SEL_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCW;

    localparam logic [SCW-1:0]    CODE_CHIPS = SCW'(1023);
    localparam logic [CHIP_W-1:0] LAST_CHIP  = CHIP_W'(1022);
    localparam logic [PRN_W-1:0]  PRN_MIN    = PRN_W'(1);
    localparam logic [PRN_W-1:0]  PRN_MAX    = PRN_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_PRN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPM = 1'b1;

    localparam logic signed [1:0] SAMPLE_POS = 2'sb01;
    localparam logic signed [1:0] SAMPLE_NEG = 2'sb11;

    typedef struct packed {
        logic [LFSR_W-1:0] g1;
        logic [LFSR_W-1:0] g2;
        logic [SCW-1:0]    phase;
        logic [SCW-1:0]    scount;
        logic [CHIP_W-1:0] chip;
    } state_t;

    localparam int STATE_W = $bits(state_t);

    typedef struct packed {
        logic signed [1:0] sample;
        logic [CHIP_W-1:0] chip_index;
        logic              last;
    } result_t;

    function automatic state_t epoch_state();
        state_t s;
        s.g1     = '1;
        s.g2     = '1;
        s.phase  = '0;
        s.scount = '0;
        s.chip   = '0;
        return s;
    endfunction

    // Mask of the two G2 phase-select cells (cell k in bit k-1), by PRN-1.
    function automatic logic [LFSR_W-1:0] g2_tap_mask(input logic [SEL_W-1:0] sel);
        logic [LFSR_W-1:0] m;
        unique case (sel)
            5'd0:  m = 10'b0000100010; // 2,6
            5'd1:  m = 10'b0001000100; // 3,7
            5'd2:  m = 10'b0010001000; // 4,8
            5'd3:  m = 10'b0100010000; // 5,9
            5'd4:  m = 10'b0100000001; // 1,9
            5'd5:  m = 10'b1000000010; // 2,10
            5'd6:  m = 10'b0010000001; // 1,8
            5'd7:  m = 10'b0100000010; // 2,9
            5'd8:  m = 10'b1000000100; // 3,10
            5'd9:  m = 10'b0000000110; // 2,3
            5'd10: m = 10'b0000001100; // 3,4
            5'd11: m = 10'b0000110000; // 5,6
            5'd12: m = 10'b0001100000; // 6,7
            5'd13: m = 10'b0011000000; // 7,8
            5'd14: m = 10'b0110000000; // 8,9
            5'd15: m = 10'b1100000000; // 9,10
            5'd16: m = 10'b0000001001; // 1,4
            5'd17: m = 10'b0000010010; // 2,5
            5'd18: m = 10'b0000100100; // 3,6
            5'd19: m = 10'b0001001000; // 4,7
            5'd20: m = 10'b0010010000; // 5,8
            5'd21: m = 10'b0100100000; // 6,9
            5'd22: m = 10'b0000000101; // 1,3
            5'd23: m = 10'b0000101000; // 4,6
            5'd24: m = 10'b0001010000; // 5,7
            5'd25: m = 10'b0010100000; // 6,8
            5'd26: m = 10'b0101000000; // 7,9
            5'd27: m = 10'b1010000000; // 8,10
            5'd28: m = 10'b0000100001; // 1,6
            5'd29: m = 10'b0001000010; // 2,7
            5'd30: m = 10'b0010000100; // 3,8
            default: m = 10'b0100001000; // 4,9
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/gcsg_ram.sv
// Generic single-port-write, registered-read RAM.
module gcsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gcsg_step.sv
// One sample step: chip value, last flag and the next generator state.
module gcsg_step
    import gcsg_pkg::*;
(
    input  state_t           cur,
    input  logic             restart,
    input  logic [PRN_W-1:0] prn,
    input  logic [SCW-1:0]   spm,
    output result_t          res,
    output state_t           nxt
);

    state_t            s;
    logic [SEL_W-1:0]  sel;
    logic              chip_bit;
    logic              last;
    logic [SCW:0]      acc_sum;
    logic              wrap;
    logic              f1;
    logic              f2;

    always_comb begin
        s        = restart ? epoch_state() : cur;
        sel      = SEL_W'(prn - PRN_W'(1));
        chip_bit = s.g1[9] ^ (^(s.g2 & g2_tap_mask(sel)));
        last     = (s.scount >= (spm - SCW'(1)));

        res.sample     = chip_bit ? SAMPLE_NEG : SAMPLE_POS;
        res.chip_index = s.chip;
        res.last       = last;

        acc_sum = {1'b0, s.phase} + {1'b0, CODE_CHIPS};
        wrap    = (acc_sum >= {1'b0, spm});
        f1      = s.g1[2] ^ s.g1[9];
        f2      = s.g2[1] ^ s.g2[2] ^ s.g2[5] ^ s.g2[7] ^ s.g2[8] ^ s.g2[9];

        nxt        = s;
        nxt.scount = s.scount + SCW'(1);
        nxt.phase  = wrap ? SCW'(acc_sum - {1'b0, spm}) : SCW'(acc_sum);
        if (wrap && (s.chip < LAST_CHIP)) begin
            nxt.g1   = {s.g1[LFSR_W-2:0], f1};
            nxt.g2   = {s.g2[LFSR_W-2:0], f2};
            nxt.chip = s.chip + CHIP_W'(1);
        end
        if (last) begin
            nxt = epoch_state();
        end
    end

endmodule

FILE: rtl/gps_ca_code_sample_generator.sv
// GPS L1 C/A Gold code sample generator, top level.
//
// Usage:
//   s_ channel: one request per output sample; s_tdata[0] = restart, which
//     returns to the code epoch before that sample is made.
//   m_ channel: one result per request; m_tdata holds sample (+1/-1, two's
//     complement) and chip_index, m_tlast marks the final sample of the
//     1 ms period, after which the generator restarts at the epoch.
//   cfg_: prn (index 0, clamped to 1..32) and samples_per_ms (index 1,
//     clamped to at least 1023); write only while idle.
// Output: each result is registered and appears in the cycle after its request is accepted.
// Throughput: one sample per clock unless m_tready stalls. The generator state word
//   (LFSRs, phase accumulator, counters) lives in a one-entry RAM with registered
//   read; the word written last cycle is forwarded so back-to-back requests chain.
// Reset: prn = 1, samples_per_ms = 1023, state at the epoch (RAM contents
//   are ignored until the first request writes them).
// Stall: the output register holds its result while m_tready is low, and
//   s_tready drops until the result is taken; nothing is lost or repeated.
`include "gps_ca_code_sample_generator_defines.svh"

module gps_ca_code_sample_generator
    import gcsg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [1:0] sample, [11:2] chip_index, [15:12] zero
    output logic                  m_tlast    // last sample of the period
);

    // configuration
    logic [PRN_W-1:0] prn_reg;
    logic [SCW-1:0]   spm_reg;
    logic [PRN_W-1:0] prn_wr;
    logic [SCW-1:0]   spm_wr;

    // state word path
    state_t           ram_rdata;
    state_t           cur_state;
    state_t           nxt_state;
    state_t           fwd_reg;
    logic             fwd_valid_reg;
    logic             init_reg;     // set once the RAM holds a written state
    result_t          step_res;

    // output register
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             m_tlast_reg;

    logic             s_accept;

    // ---- configuration writes, clamped to range ----
    always_comb begin
        prn_wr = cfg_wdata[PRN_W-1:0];
        if (prn_wr < PRN_MIN) begin
            prn_wr = PRN_MIN;
        end else if (prn_wr > PRN_MAX) begin
            prn_wr = PRN_MAX;
        end
        spm_wr = cfg_wdata[SCW-1:0];
        if (spm_wr < CODE_CHIPS) begin
            spm_wr = CODE_CHIPS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prn_reg <= PRN_MIN;
            spm_reg <= CODE_CHIPS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PRN: prn_reg <= prn_wr;
                REG_SPM: spm_reg <= spm_wr;
                default: ;
            endcase
        end
    end

    // ---- handshake: a new request is taken whenever the output slot frees ----
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // ---- state word: RAM read every cycle, forward last cycle's write ----
    gcsg_ram #(
        .WIDTH (STATE_W),
        .DEPTH (1)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (1'b0),
        .wdata (nxt_state),
        .re    (1'b1),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (!init_reg) begin
            cur_state = epoch_state();
        end else if (fwd_valid_reg) begin
            cur_state = fwd_reg;
        end else begin
            cur_state = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
            init_reg      <= 1'b0;
        end else begin
            fwd_valid_reg <= s_accept;
            if (s_accept) begin
                init_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_reg <= nxt_state;
        end
    end

    gcsg_step u_step (
        .cur     (cur_state),
        .restart (s_tdata[0]),
        .prn     (prn_reg),
        .spm     (spm_reg),
        .res     (step_res),
        .nxt     (nxt_state)
    );

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {4'b0000, step_res.chip_index, step_res.sample};
            m_tlast_reg <= step_res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---- checks ----
    `GCSG_ASSERT_NOW(a_chip_bound, aclk, aresetn, 1'b1, cur_state.chip <= LAST_CHIP)
    `GCSG_ASSERT_NEXT(a_restart_chip0, aclk, aresetn, s_accept && s_tdata[0], m_tvalid && (m_tdata[11:2] == '0))
    `GCSG_ASSERT_NEXT(a_last_epoch, aclk, aresetn, s_accept && step_res.last, cur_state == epoch_state())

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the GPS C/A code sample generator.
module tb_top;
    import gcsg_pkg::*;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // [1:0] sample, [11:2] chip_index, [15:12] zero
    logic                  m_tlast;   // last sample of the 1 ms period

    gps_ca_code_sample_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 4-unit clock period
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #800000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Expected sample and the directed stimulus table
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [1:0] value;
        logic [9:0]        chip;
        logic              last;
    } sample_t;

    typedef enum logic { ROW_REQ, ROW_WR } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  restart;
        logic                  typed;     // want holds a hand-written expectation
        sample_t               want;
    } row_t;

    // Every PRN starts its code with chip 1 (all cells ones), so the first
    // sample after reset or restart is -1 at chip 0.
    localparam sample_t EPOCH_SAMPLE = '{SAMPLE_NEG, 10'd0, 1'b0};
    localparam sample_t NO_WANT      = '{SAMPLE_POS, 10'd0, 1'b0};
    localparam int      DIR_ROWS     = 24;

    row_t dir_rows [0:DIR_ROWS-1];

    // ------------------------------------------------------------------
    // Predictor state: configuration and generator state
    // ------------------------------------------------------------------
    logic [PRN_W-1:0]  prn_q;
    logic [SCW-1:0]    spm_q;
    logic [9:0]        g1_q;
    logic [9:0]        g2_q;
    int unsigned       phase_q;   // wider than the block, never wraps here
    logic [SCW-1:0]    count_q;
    logic [CHIP_W-1:0] chip_q;

    sample_t pending_samples [$];

    int mismatch_count;
    int requests_sent;
    int restarts_sent;
    int results_seen;
    int period_ends;
    int settings_count;
    int send_idle_pct;
    int recv_idle_pct;

    // G2 phase-select cell pair {a, b} for PRN sel+1
    function automatic logic [7:0] tap_pair(input logic [SEL_W-1:0] sel);
        case (sel)
            5'd0:  return {4'd2, 4'd6};   5'd1:  return {4'd3, 4'd7};
            5'd2:  return {4'd4, 4'd8};   5'd3:  return {4'd5, 4'd9};
            5'd4:  return {4'd1, 4'd9};   5'd5:  return {4'd2, 4'd10};
            5'd6:  return {4'd1, 4'd8};   5'd7:  return {4'd2, 4'd9};
            5'd8:  return {4'd3, 4'd10};  5'd9:  return {4'd2, 4'd3};
            5'd10: return {4'd3, 4'd4};   5'd11: return {4'd5, 4'd6};
            5'd12: return {4'd6, 4'd7};   5'd13: return {4'd7, 4'd8};
            5'd14: return {4'd8, 4'd9};   5'd15: return {4'd9, 4'd10};
            5'd16: return {4'd1, 4'd4};   5'd17: return {4'd2, 4'd5};
            5'd18: return {4'd3, 4'd6};   5'd19: return {4'd4, 4'd7};
            5'd20: return {4'd5, 4'd8};   5'd21: return {4'd6, 4'd9};
            5'd22: return {4'd1, 4'd3};   5'd23: return {4'd4, 4'd6};
            5'd24: return {4'd5, 4'd7};   5'd25: return {4'd6, 4'd8};
            5'd26: return {4'd7, 4'd9};   5'd27: return {4'd8, 4'd10};
            5'd28: return {4'd1, 4'd6};   5'd29: return {4'd2, 4'd7};
            5'd30: return {4'd3, 4'd8};   default: return {4'd4, 4'd9};
        endcase
    endfunction

    function automatic void go_to_epoch();
        g1_q    = '1;
        g2_q    = '1;
        phase_q = 0;
        count_q = '0;
        chip_q  = '0;
    endfunction

    // One sample of the code replica; advances the predictor state.
    function automatic sample_t predict_sample(input logic restart);
        logic [7:0] taps;
        logic       chip_bit;
        sample_t    r;
        if (restart)
            go_to_epoch();
        taps     = tap_pair(SEL_W'(prn_q - 1));
        chip_bit = g1_q[9] ^ g2_q[taps[7:4] - 1] ^ g2_q[taps[3:0] - 1];
        r.value  = chip_bit ? SAMPLE_NEG : SAMPLE_POS;
        r.chip   = chip_q;
        r.last   = (count_q >= spm_q - 1'b1);
        if (r.last) begin
            go_to_epoch();
        end else begin
            count_q = count_q + 1'b1;
            phase_q = phase_q + 1023;
            // accumulator wraps: step to the next chip, unless parked at the last one
            if (phase_q >= spm_q) begin
                phase_q = phase_q - spm_q;
                if (chip_q < LAST_CHIP) begin
                    g1_q   = {g1_q[8:0], g1_q[2] ^ g1_q[9]};
                    // G2 feedback: cells 2,3,6,8,9,10
                    g2_q   = {g2_q[8:0], ^(g2_q & 10'b1110100110)};
                    chip_q = chip_q + 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    // Offer one request, wait for acceptance, queue its expected sample.
    // A typed expectation replaces the predicted one but the predictor
    // still advances so later rows stay in step.
    task automatic push_request(input logic restart, input logic typed,
                                input sample_t want);
        sample_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        p = predict_sample(restart);
        pending_samples.push_back(typed ? want : p);
        requests_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // Register write, only once every pending sample has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic [PRN_W-1:0] p;
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        // clamp the same way the block does; prn keeps only its 6 bits
        if (idx == REG_PRN) begin
            p = val[PRN_W-1:0];
            if (p < PRN_MIN)
                p = PRN_MIN;
            if (p > PRN_MAX)
                p = PRN_MAX;
            prn_q = p;
        end else begin
            spm_q = (val < CODE_CHIPS) ? CODE_CHIPS : val;
        end
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: m_tready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    int  taken_count;
    int  hold_left;
    bit  hold_done;

    initial begin
        taken_count = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
    end

    // Once 600 results are taken, hold m_tready low until the hold-off counter runs out, so the
    // block backs up and drops s_tready while requests keep coming.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            taken_count++;
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && taken_count >= 600) begin
            hold_done = 1'b1;
            hold_left = 299;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tlast)
                period_ends++;
            if (pending_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: sample %0d chip %0d last %0b",
                             $signed(m_tdata[1:0]), m_tdata[11:2], m_tlast);
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[1:0] !== want.value || m_tdata[11:2] !== want.chip ||
                    m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at result %0d: want %0d/%0d/%0b got %0d/%0d/%0b",
                                 results_seen, want.value, want.chip, want.last,
                                 $signed(m_tdata[1:0]), m_tdata[11:2], m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int               ph;
        int               len;
        int               drain;
        logic [CFG_DATA_W-1:0] spm_val;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;

        mismatch_count = 0;
        requests_sent  = 0;
        restarts_sent  = 0;
        results_seen   = 0;
        period_ends    = 0;
        settings_count = 0;
        send_idle_pct  = 18;
        recv_idle_pct  = 60;

        prn_q = PRN_MIN;
        spm_q = CODE_CHIPS;
        go_to_epoch();

        // Directed part: reset values, clamping at both ends of prn and at the
        // low end of samples_per_ms, prn masked to its 6 bits, restart, longest period,
        // and a shrink of the period while one is running.
        dir_rows = '{
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b1, EPOCH_SAMPLE},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b1, 1'b1, EPOCH_SAMPLE},
            '{ROW_WR,  REG_PRN, 26'd0,        1'b0, 1'b0, NO_WANT},     // below range
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_WR,  REG_PRN, 26'd63,       1'b0, 1'b0, NO_WANT},     // above range
            '{ROW_REQ, REG_PRN, '0,           1'b1, 1'b1, EPOCH_SAMPLE},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_WR,  REG_PRN, 26'h3FFFFC0,  1'b0, 1'b0, NO_WANT},     // low bits zero
            '{ROW_WR,  REG_SPM, 26'd0,        1'b0, 1'b0, NO_WANT},     // clamps to 1023
            '{ROW_REQ, REG_PRN, '0,           1'b1, 1'b1, EPOCH_SAMPLE},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_WR,  REG_SPM, 26'h3FFFFFF,  1'b0, 1'b0, NO_WANT},     // longest period
            '{ROW_WR,  REG_PRN, 26'd17,       1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b1, 1'b1, EPOCH_SAMPLE},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_WR,  REG_SPM, 26'd1022,     1'b0, 1'b0, NO_WANT},     // just below range
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT},
            '{ROW_REQ, REG_PRN, '0,           1'b1, 1'b1, EPOCH_SAMPLE},
            '{ROW_REQ, REG_PRN, '0,           1'b0, 1'b0, NO_WANT}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_WR)
                write_reg(dir_rows[i].idx, dir_rows[i].wdata);
            else
                push_request(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].want);
        end

        // Chip overrun: run 1000 chips at one sample per chip, then stretch
        // the period to 1100 mid-period. The chip counter reaches 1022 and
        // parks there until the period ends; the epoch follows.
        write_reg(REG_SPM, CODE_CHIPS);
        write_reg(REG_PRN, 26'd5);
        push_request(1'b1, 1'b0, NO_WANT);
        repeat (999) push_request(1'b0, 1'b0, NO_WANT);
        write_reg(REG_SPM, 26'd1100);
        repeat (120) push_request(1'b0, 1'b0, NO_WANT);

        // Random phases. The first 32 walk every PRN; state carries across
        // phases, so a shorter period written late ends the current one.
        for (ph = 0; ph < 48; ph++) begin
            if (ph < 16) begin
                send_idle_pct = 18;
                recv_idle_pct = 60;
            end else if (ph < 32) begin
                send_idle_pct = 60;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph < 32)
                write_reg(REG_PRN, CFG_DATA_W'(ph + 1));
            else if ($urandom_range(3) != 0)
                write_reg(REG_PRN, CFG_DATA_W'($urandom));
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: spm_val = CODE_CHIPS;
                    4, 5, 6:    spm_val = CODE_CHIPS + CFG_DATA_W'($urandom_range(200));
                    7, 8:       spm_val = CFG_DATA_W'($urandom_range(4095));
                    default:    spm_val = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_SPM, spm_val);
            end
            len = $urandom_range(6, 2);
            repeat (len) push_request($urandom_range(149) == 0, 1'b0, NO_WANT);
        end

        // Drain, then keep watching for any stray result.
        s_tvalid <= 1'b0;
        drain = 0;
        while (pending_samples.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4) @(posedge aclk);
        if (pending_samples.size() != 0) begin
            $display("%0d expected samples never arrived", pending_samples.size());
            mismatch_count += pending_samples.size();
        end

        $display("%0d requests (%0d restarts) under %0d register writes, all 32 PRNs",
                 requests_sent, restarts_sent, settings_count);
        $display("%0d results checked, %0d period ends, %0d mismatches",
                 results_seen, period_ends, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
